[rtl/core/pls_pkg.sv]
// Shared types and constants for the positional list store.
// Holds command and status codes, cell operation codes and cell control struct.
// No dependencies.
package pls_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;
  localparam int WHERE_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_SEARCH    = 3'd6,
    CMD_DUMP      = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] idx;
  } cell_ctl_t;

endpackage

[rtl/core/pls_cell.sv]
// One storage cell of the positional list store chain.
// Holds one element; shifts toward either neighbor, loads, or wraps the head.
// Depends on pls_pkg.
module pls_cell (
  input  logic                      clk,
  input  pls_pkg::cell_ctl_t        ctl,
  input  logic [pls_pkg::IDX_W-1:0] my_idx,
  input  logic [pls_pkg::CNT_W-1:0] len,
  input  logic [pls_pkg::DATA_W-1:0] key,
  input  logic [pls_pkg::DATA_W-1:0] left_data,
  input  logic [pls_pkg::DATA_W-1:0] right_data,
  input  logic [pls_pkg::DATA_W-1:0] head_data,
  output logic [pls_pkg::DATA_W-1:0] data,
  output logic                      match
);
  import pls_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [CNT_W-1:0]  my_pos;
  logic [CNT_W-1:0]  tail;

  assign my_pos = CNT_W'(my_idx);
  assign tail   = len - CNT_W'(1);

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_INS: begin
        if (my_idx > ctl.idx) data_nxt = left_data;
        else if (my_idx == ctl.idx) data_nxt = key;
      end
      OP_DEL: begin
        if (my_idx >= ctl.idx) data_nxt = right_data;
      end
      OP_ROT: begin
        if (my_pos == tail) data_nxt = head_data;
        else if (my_pos < tail) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == key) && (my_pos < len);

endmodule

[rtl/core/positional_list_store.sv]
// Top level of the positional list store: command decode, length, result register.
// Instantiates a chain of pls_cell; depends on pls_pkg.
//
// For every command but dump the cell chain shifts, loads or compares all
// entries at once and one result appears in the cycle after start. A dump
// gives one result a cycle as the chain rotates the head element out through
// the tail; busy is high while the elements after the first rotate out. An
// empty dump gives a single EMPTY result. Results come as a one-cycle out_valid
// strobe and cannot be stalled. The list holds up to 16 elements.
module positional_list_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [pls_pkg::CMD_W-1:0]   in_cmd,
  input  logic [pls_pkg::POS_W-1:0]   in_position,
  input  logic [pls_pkg::DATA_W-1:0]  in_value,
  output logic                        out_valid,
  output logic [pls_pkg::STAT_W-1:0]  out_status,
  output logic [pls_pkg::DATA_W-1:0]  out_data,
  output logic [pls_pkg::WHERE_W-1:0] out_where,
  output logic                        out_last
);
  import pls_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              valid_r, valid_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] odata_r, odata_nxt;
  logic [WHERE_W-1:0] where_r, where_nxt;
  logic              last_r, last_nxt;

  cell_ctl_t         ctl;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;

  logic [POS_W-1:0]  len_pos;
  logic [DATA_W-1:0] sel_data;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic              accept;

  assign busy    = (state_r == S_DUMP);
  assign accept  = start && (state_r == S_IDLE);
  assign len_pos = POS_W'(len_r);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;
      if (g == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_lastc
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = cell_data[g+1];
      end
      pls_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .my_idx     (IDX_W'(g)),
        .len        (len_r),
        .key        (in_value),
        .left_data  (left_d),
        .right_data (right_d),
        .head_data  (cell_data[0]),
        .data       (cell_data[g]),
        .match      (cell_match[g])
      );
    end
  endgenerate

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (IDX_W'(i) == ctl.idx) sel_data = sel_data | cell_data[i];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    valid_nxt  = 1'b0;
    status_nxt = ST_OK;
    odata_nxt  = '0;
    where_nxt  = '0;
    last_nxt   = 1'b1;
    ctl.op     = OP_HOLD;
    ctl.idx    = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          valid_nxt = 1'b1;
          case (in_cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
              if (len_r >= CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else if (in_cmd == CMD_INS_FRONT ||
                           (in_cmd == CMD_INS_AT &&
                            (in_position <= POS_W'(1) || len_r == '0))) begin
                ctl.op  = OP_INS;
                len_nxt = len_r + CNT_W'(1);
              end else if (in_cmd == CMD_INS_BACK) begin
                ctl.op  = OP_INS;
                ctl.idx = IDX_W'(len_r);
                len_nxt = len_r + CNT_W'(1);
              end else if (in_position > len_pos + POS_W'(1)) begin
                status_nxt = ST_RANGE;
              end else begin
                ctl.op  = OP_INS;
                ctl.idx = IDX_W'(in_position - POS_W'(1));
                len_nxt = len_r + CNT_W'(1);
              end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
              if (len_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (in_cmd == CMD_DEL_AT &&
                           (in_position == '0 || in_position > len_pos)) begin
                status_nxt = ST_RANGE;
              end else begin
                if (in_cmd == CMD_DEL_BACK) ctl.idx = IDX_W'(len_r - CNT_W'(1));
                else if (in_cmd == CMD_DEL_AT) ctl.idx = IDX_W'(in_position - POS_W'(1));
                ctl.op    = OP_DEL;
                len_nxt   = len_r - CNT_W'(1);
                odata_nxt = sel_data;
                where_nxt = WHERE_W'(CNT_W'(ctl.idx) + CNT_W'(1));
              end
            end
            CMD_SEARCH: begin
              if (len_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (found) begin
                odata_nxt = in_value;
                where_nxt = WHERE_W'(CNT_W'(found_idx) + CNT_W'(1));
              end else begin
                status_nxt = ST_RANGE;
              end
            end
            CMD_DUMP: begin
              if (len_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                ctl.op    = OP_ROT;
                odata_nxt = cell_data[0];
                where_nxt = WHERE_W'(1);
                last_nxt  = (len_r == CNT_W'(1));
                cnt_nxt   = CNT_W'(2);
                if (len_r != CNT_W'(1)) state_nxt = S_DUMP;
              end
            end
            default: status_nxt = ST_RANGE;
          endcase
        end
      end
      S_DUMP: begin
        valid_nxt = 1'b1;
        ctl.op    = OP_ROT;
        odata_nxt = cell_data[0];
        where_nxt = WHERE_W'(cnt_r);
        last_nxt  = (cnt_r == len_r);
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == len_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    odata_r  <= odata_nxt;
    where_r  <= where_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_data   = odata_r;
  assign out_where  = where_r;
  assign out_last   = last_r;

endmodule
